// ----- sv/dsrm_pkg.sv -----
// Shared types, constants and payload layouts of the DMA slot ring manager.
package dsrm_pkg;

  parameter int unsigned SLOT_COUNT = 32;
  parameter int unsigned SLOT_W     = $clog2(SLOT_COUNT);
  parameter int unsigned ORD_W      = 64;
  parameter int unsigned WORD_W     = 32;

  parameter int unsigned IN_DATA_W  = 224;
  parameter int unsigned OUT_DATA_W = 240;
  parameter int unsigned CFG_IDX_W  = 3;

  typedef enum logic [1:0] {
    OP_PUSH    = 2'd0,
    OP_ACQUIRE = 2'd1,
    OP_RELEASE = 2'd2,
    OP_POLL    = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    STS_OK      = 3'd0,
    STS_INVALID = 3'd1,
    STS_EMPTY   = 3'd2,
    STS_FULL    = 3'd3,
    STS_STALE   = 3'd4
  } sts_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STREAM   = 3'd0,
    CFG_PTYPE    = 3'd1,
    CFG_CHANNELS = 3'd2,
    CFG_FORMAT   = 3'd3,
    CFG_SAMPLES  = 3'd4,
    CFG_RUNNING  = 3'd5
  } cfg_e;

  // Input payload, last field in the lowest bits.
  typedef struct packed {
    logic [5:0]        pad;
    logic [WORD_W-1:0] generation;
    logic [7:0]        rel_slot;
    logic [WORD_W-1:0] buffer_address;
    logic [WORD_W-1:0] length_bytes;
    logic [WORD_W-1:0] declared_bytes;
    logic [WORD_W-1:0] frame_samples;
    logic [7:0]        fmt_code;
    logic [1:0]        chan_set;
    logic [7:0]        pkt_kind;
    logic [WORD_W-1:0] stream_tag;
  } in_data_t;

  // Result payload, last field in the lowest bits.
  typedef struct packed {
    logic [3:0]        pad;
    logic [WORD_W-1:0] dropped_count;
    logic [WORD_W-1:0] released_count;
    logic [WORD_W-1:0] acquired_count;
    logic [WORD_W-1:0] produced_count;
    logic              ready_any;
    logic [WORD_W-1:0] out_address;
    logic [WORD_W-1:0] out_bytes;
    logic [WORD_W-1:0] out_generation;
    logic [7:0]        out_slot;
    logic [2:0]        status;
  } out_data_t;

  // Control of the scan compare unit for one slot per cycle.
  typedef struct packed {
    logic              clear;
    logic              valid;
    logic [SLOT_W-1:0] idx;
    logic              cand;
    logic              oldest;
  } scan_ctl_t;

  // Write of one slot entry in the store.
  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
    logic [WORD_W-1:0] generation;
    logic [ORD_W-1:0]  order;
    logic [WORD_W-1:0] bytes;
    logic [WORD_W-1:0] address;
  } slot_wr_t;

endpackage

// ----- sv/dsrm_slot_store.sv -----
// Per-slot memories: generation, insertion order, byte count and buffer address.
module dsrm_slot_store (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [dsrm_pkg::SLOT_W-1:0]  rd_addr_i,
  input  dsrm_pkg::slot_wr_t           wr_i,
  output logic [dsrm_pkg::WORD_W-1:0]  rd_generation_o,
  output logic [dsrm_pkg::ORD_W-1:0]   rd_order_o,
  output logic [dsrm_pkg::WORD_W-1:0]  rd_bytes_o,
  output logic [dsrm_pkg::WORD_W-1:0]  rd_address_o
);
  import dsrm_pkg::*;

  logic [WORD_W-1:0] gen_mem  [SLOT_COUNT];
  logic [ORD_W-1:0]  ord_mem  [SLOT_COUNT];
  logic [WORD_W-1:0] byte_mem [SLOT_COUNT];
  logic [WORD_W-1:0] addr_mem [SLOT_COUNT];

  // A generation never written reads as zero.
  logic [SLOT_COUNT-1:0] gen_vld_q;
  logic                  rd_vld_q;
  logic [WORD_W-1:0]     gen_rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      gen_mem[wr_i.addr]  <= wr_i.generation;
      ord_mem[wr_i.addr]  <= wr_i.order;
      byte_mem[wr_i.addr] <= wr_i.bytes;
      addr_mem[wr_i.addr] <= wr_i.address;
    end
    gen_rd_q     <= gen_mem[rd_addr_i];
    rd_order_o   <= ord_mem[rd_addr_i];
    rd_bytes_o   <= byte_mem[rd_addr_i];
    rd_address_o <= addr_mem[rd_addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (wr_i.en) begin
        gen_vld_q[wr_i.addr] <= 1'b1;
      end
      rd_vld_q <= gen_vld_q[rd_addr_i];
    end
  end

  assign rd_generation_o = rd_vld_q ? gen_rd_q : '0;

endmodule

// ----- sv/dsrm_order_cmp.sv -----
// Shared scan unit: picks the first matching slot or the one with the oldest stamp.
module dsrm_order_cmp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  dsrm_pkg::scan_ctl_t          ctl_i,
  input  logic [dsrm_pkg::ORD_W-1:0]   rd_order_i,
  output logic                         found_o,
  output logic [dsrm_pkg::SLOT_W-1:0]  best_idx_o
);
  import dsrm_pkg::*;

  // Stage aligned with the registered read of the order memory.
  logic              p_vld_q;
  logic              p_cand_q;
  logic              p_oldest_q;
  logic [SLOT_W-1:0] p_idx_q;

  logic              found_q;
  logic [SLOT_W-1:0] best_idx_q;
  logic [ORD_W-1:0]  best_ord_q;
  logic              take;

  assign take = p_vld_q && p_cand_q &&
                (!found_q || (p_oldest_q && (rd_order_i < best_ord_q)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
      found_q <= 1'b0;
    end else begin
      p_vld_q <= ctl_i.valid;
      if (ctl_i.clear) begin
        found_q <= 1'b0;
      end else if (take) begin
        found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    p_cand_q   <= ctl_i.cand;
    p_oldest_q <= ctl_i.oldest;
    p_idx_q    <= ctl_i.idx;
    if (take) begin
      best_idx_q <= p_idx_q;
      best_ord_q <= rd_order_i;
    end
  end

  assign found_o    = found_q;
  assign best_idx_o = best_idx_q;

endmodule

// ----- sv/dma_slot_ring_manager.sv -----
// Top level of the DMA slot ring manager: sequencer, slot states, counters and ports.
//
// The block keeps a pool of SLOT_COUNT buffer slots, each free, ready or held by
// the user. Commands arrive as transactions on the slave stream: tuser carries the
// operation (push, acquire, release, poll) and tdata the push metadata and the
// release target. Every command yields exactly one result transaction on the
// master stream, carrying a status, the acquired slot's details, the poll flag
// and the four wrapping event counters.
// Configuration registers are written through the cfg channel, which is always
// ready; writes are expected only while no command is in flight.
// Push, acquire and poll walk all slots through one shared compare unit, one slot
// per cycle; a push or acquire that finds a slot then passes through drain, decide,
// fetch and update before its result is offered, and any other scan goes from
// decide to done. A release passes through fetch and update, and a command rejected
// on its arguments goes straight to done; idle is reached as the result is offered.
// The slave side is ready only while the sequencer is idle, so one command is
// worked on at a time. A finished result sits in an output register; while the
// receiver stalls, a following command is still accepted and processed, and its
// result waits until the register has been taken.
// Reset marks every slot free with generation zero, clears all counters and config
// registers, and leaves both stream sides empty; no clearing pass is needed.
module dma_slot_ring_manager (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Command stream.
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata, lowest bit up: stream_tag, pkt_kind, chan_set, fmt_code,
  // frame_samples, declared_bytes, length_bytes, buffer_address, rel_slot,
  // generation, zero padding.
  input  logic [dsrm_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // tuser, lowest bit up: op.
  input  logic [1:0]                         s_axis_tuser,
  // Result stream.
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // tdata, lowest bit up: status, out_slot, out_generation, out_bytes,
  // out_address, ready_any, produced_count, acquired_count, released_count,
  // dropped_count, zero padding.
  output logic [dsrm_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // Configuration write channel.
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [dsrm_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [dsrm_pkg::WORD_W-1:0]        cfg_data_i
);
  import dsrm_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SCAN   = 7'b0000010,
    S_DRAIN  = 7'b0000100,
    S_DECIDE = 7'b0001000,
    S_FETCH  = 7'b0010000,
    S_UPDATE = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic [WORD_W-1:0] exp_stream_q;
  logic [7:0]        exp_ptype_q;
  logic [1:0]        exp_chans_q;
  logic [7:0]        exp_format_q;
  logic [WORD_W-1:0] exp_samples_q;
  logic              running_q;

  // Slot states: ready and held by the user; a slot with neither is free.
  logic [SLOT_COUNT-1:0] ready_q;
  logic [SLOT_COUNT-1:0] user_q;

  logic [ORD_W-1:0]  order_cnt_q;
  logic [WORD_W-1:0] produced_q;
  logic [WORD_W-1:0] acquired_q;
  logic [WORD_W-1:0] released_q;
  logic [WORD_W-1:0] dropped_q;

  // Latched command.
  op_e               op_q;
  logic [WORD_W-1:0] length_q;
  logic [WORD_W-1:0] address_q;
  logic [WORD_W-1:0] gen_q;

  logic [SLOT_W-1:0] cnt_q;
  logic [SLOT_W-1:0] tgt_q;

  // Result fields built up while a command runs.
  sts_e              sts_q;
  logic [7:0]        res_slot_q;
  logic [WORD_W-1:0] res_gen_q;
  logic [WORD_W-1:0] res_bytes_q;
  logic [WORD_W-1:0] res_addr_q;
  logic              res_ready_q;

  out_data_t out_q;
  logic      out_vld_q;

  in_data_t  in_data;
  op_e       in_op;
  logic      in_fire;
  logic      push_ok;
  logic      pool_active;
  logic      idx_in_range;
  logic      out_free;

  scan_ctl_t         scan_ctl;
  logic              scan_found;
  logic [SLOT_W-1:0] scan_best;
  slot_wr_t          wr;
  logic [SLOT_W-1:0] rd_addr;
  logic [WORD_W-1:0] rd_gen;
  logic [ORD_W-1:0]  rd_order;
  logic [WORD_W-1:0] rd_bytes;
  logic [WORD_W-1:0] rd_address;
  logic [WORD_W-1:0] gen_inc;
  logic [WORD_W-1:0] gen_new;

  assign in_data = in_data_t'(s_axis_tdata);
  assign in_op   = op_e'(s_axis_tuser);
  assign in_fire = s_axis_tvalid && s_axis_tready;

  assign s_axis_tready = (state_q == S_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign out_free      = !out_vld_q || m_axis_tready;

  assign pool_active  = running_q && (exp_stream_q != '0);
  assign idx_in_range = ({1'b0, in_data.rel_slot} < 9'(SLOT_COUNT));

  // A push must match every configured field, and its declared and actual
  // lengths must agree and be non-zero.
  assign push_ok = (in_data.length_bytes != '0) && (exp_stream_q != '0) &&
                   (in_data.stream_tag == exp_stream_q) &&
                   (in_data.pkt_kind == exp_ptype_q) &&
                   (in_data.chan_set == exp_chans_q) &&
                   (in_data.fmt_code == exp_format_q) &&
                   (in_data.frame_samples == exp_samples_q) &&
                   (in_data.declared_bytes == in_data.length_bytes);

  // Scan: one slot per cycle into the shared compare unit. A push takes the
  // first free slot, acquire and poll the ready slot with the smallest stamp.
  always_comb begin
    scan_ctl.clear  = in_fire;
    scan_ctl.valid  = (state_q == S_SCAN);
    scan_ctl.idx    = cnt_q;
    scan_ctl.oldest = (op_q != OP_PUSH);
    if (op_q == OP_PUSH) begin
      scan_ctl.cand = !ready_q[cnt_q] && !user_q[cnt_q];
    end else begin
      scan_ctl.cand = ready_q[cnt_q];
    end
  end

  assign rd_addr = (state_q == S_SCAN) ? cnt_q : tgt_q;

  // Generation advances on every push that takes a slot and skips zero.
  assign gen_inc = rd_gen + WORD_W'(1);
  assign gen_new = (gen_inc == '0) ? WORD_W'(1) : gen_inc;

  always_comb begin
    wr.en         = (state_q == S_UPDATE) && (op_q == OP_PUSH);
    wr.addr       = tgt_q;
    wr.generation = gen_new;
    wr.order      = order_cnt_q + ORD_W'(1);
    wr.bytes      = length_q;
    wr.address    = address_q;
  end

  dsrm_order_cmp u_cmp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (scan_ctl),
    .rd_order_i (rd_order),
    .found_o    (scan_found),
    .best_idx_o (scan_best)
  );

  dsrm_slot_store u_store (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .rd_addr_i       (rd_addr),
    .wr_i            (wr),
    .rd_generation_o (rd_gen),
    .rd_order_o      (rd_order),
    .rd_bytes_o      (rd_bytes),
    .rd_address_o    (rd_address)
  );

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          unique case (in_op) inside
            OP_PUSH:    state_d = push_ok ? S_SCAN : S_DONE;
            OP_ACQUIRE,
            OP_POLL:    state_d = pool_active ? S_SCAN : S_DONE;
            OP_RELEASE: state_d = idx_in_range ? S_FETCH : S_DONE;
            default:    state_d = S_DONE;
          endcase
        end
      end
      S_SCAN: begin
        if (cnt_q == SLOT_W'(SLOT_COUNT - 1)) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN:  state_d = S_DECIDE;
      S_DECIDE: begin
        if (scan_found && (op_q != OP_POLL)) begin
          state_d = S_FETCH;
        end else begin
          state_d = S_DONE;
        end
      end
      S_FETCH:  state_d = S_UPDATE;
      S_UPDATE: state_d = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default:  state_d = S_IDLE;
    endcase
  end

  // Control state, slot states and counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      exp_stream_q  <= '0;
      exp_ptype_q   <= '0;
      exp_chans_q   <= '0;
      exp_format_q  <= '0;
      exp_samples_q <= '0;
      running_q     <= 1'b0;
      ready_q       <= '0;
      user_q        <= '0;
      order_cnt_q   <= '0;
      produced_q    <= '0;
      acquired_q    <= '0;
      released_q    <= '0;
      dropped_q     <= '0;
      cnt_q         <= '0;
      out_vld_q     <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CFG_STREAM:   exp_stream_q  <= cfg_data_i;
          CFG_PTYPE:    exp_ptype_q   <= cfg_data_i[7:0];
          CFG_CHANNELS: exp_chans_q   <= cfg_data_i[1:0];
          CFG_FORMAT:   exp_format_q  <= cfg_data_i[7:0];
          CFG_SAMPLES:  exp_samples_q <= cfg_data_i;
          CFG_RUNNING:  running_q     <= cfg_data_i[0];
          default: ;
        endcase
      end

      if (in_fire) begin
        cnt_q <= '0;
      end else if (state_q == S_SCAN) begin
        cnt_q <= cnt_q + SLOT_W'(1);
      end

      if ((state_q == S_DECIDE) && !scan_found && (op_q == OP_PUSH)) begin
        dropped_q <= dropped_q + WORD_W'(1);
      end

      if (state_q == S_UPDATE) begin
        unique case (op_q)
          OP_PUSH: begin
            ready_q[tgt_q] <= 1'b1;
            order_cnt_q    <= order_cnt_q + ORD_W'(1);
            produced_q     <= produced_q + WORD_W'(1);
          end
          OP_ACQUIRE: begin
            ready_q[tgt_q] <= 1'b0;
            user_q[tgt_q]  <= 1'b1;
            acquired_q     <= acquired_q + WORD_W'(1);
          end
          OP_RELEASE: begin
            if (user_q[tgt_q] && (rd_gen == gen_q)) begin
              user_q[tgt_q] <= 1'b0;
              released_q    <= released_q + WORD_W'(1);
            end
          end
          default: ;
        endcase
      end

      if ((state_q == S_DONE) && out_free) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Command latch and result fields.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q        <= in_op;
      length_q    <= in_data.length_bytes;
      address_q   <= in_data.buffer_address;
      gen_q       <= in_data.generation;
      tgt_q       <= in_data.rel_slot[SLOT_W-1:0];
      res_slot_q  <= '0;
      res_gen_q   <= '0;
      res_bytes_q <= '0;
      res_addr_q  <= '0;
      res_ready_q <= 1'b0;
      unique case (in_op) inside
        OP_PUSH:    sts_q <= push_ok ? STS_OK : STS_INVALID;
        OP_ACQUIRE,
        OP_POLL:    sts_q <= pool_active ? STS_OK : STS_INVALID;
        OP_RELEASE: sts_q <= idx_in_range ? STS_OK : STS_INVALID;
        default:    sts_q <= STS_INVALID;
      endcase
    end

    if (state_q == S_DECIDE) begin
      tgt_q <= scan_best;
      if (op_q == OP_POLL) begin
        res_ready_q <= scan_found;
      end else if (!scan_found) begin
        sts_q <= (op_q == OP_PUSH) ? STS_FULL : STS_EMPTY;
      end
    end

    if (state_q == S_UPDATE) begin
      if (op_q == OP_ACQUIRE) begin
        res_slot_q  <= 8'(tgt_q);
        res_gen_q   <= rd_gen;
        res_bytes_q <= rd_bytes;
        res_addr_q  <= rd_address;
      end
      if ((op_q == OP_RELEASE) && !(user_q[tgt_q] && (rd_gen == gen_q))) begin
        sts_q <= STS_STALE;
      end
    end

    if ((state_q == S_DONE) && out_free) begin
      out_q.pad            <= '0;
      out_q.status         <= sts_q;
      out_q.out_slot       <= res_slot_q;
      out_q.out_generation <= res_gen_q;
      out_q.out_bytes      <= res_bytes_q;
      out_q.out_address    <= res_addr_q;
      out_q.ready_any      <= res_ready_q;
      out_q.produced_count <= produced_q;
      out_q.acquired_count <= acquired_q;
      out_q.released_count <= released_q;
      out_q.dropped_count  <= dropped_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = OUT_DATA_W'(out_q);

endmodule
